>>> hw/rtl/mlsc_pkg.sv
// ----------------------------------------------------------------------------
// mlsc_pkg: shared types and constants of the multi-link split controller
// Fixed-point format, clamp limits, register indexes and transaction payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package mlsc_pkg;

  // Fraction bits of the occupancy and split values.
  localparam int unsigned FracBits = 16;
  // Width of a Q value, which must be able to hold 1.0 itself.
  localparam int unsigned QW       = FracBits + 1;
  localparam int unsigned TimeW    = 30;
  localparam int unsigned GainW    = 16;
  // The loop gain carries 16 fraction bits of its own.
  localparam int unsigned GainFrac = 16;

  localparam longint unsigned QOneL  = longint'(1) << FracBits;
  localparam longint unsigned QLowL  = (50 * QOneL + 500) / 1000;
  localparam longint unsigned QHighL = (950 * QOneL + 500) / 1000;
  localparam longint unsigned QInitL = (808 * QOneL + 500) / 1000;

  localparam logic [QW-1:0] QOne  = QW'(QOneL);
  localparam logic [QW-1:0] QHalf = QW'(QOneL / 2);
  localparam logic [QW-1:0] QLow  = QW'(QLowL);
  localparam logic [QW-1:0] QHigh = QW'(QHighL);
  localparam logic [QW-1:0] QInit = QW'(QInitL);

  localparam logic [GainW-1:0] GainReset = 16'd13107;

  typedef enum logic [1:0] {
    CfgSchedMode = 2'd0,
    CfgLoopGain  = 2'd1
  } cfg_index_e;

  typedef enum logic [1:0] {
    ModeFixed = 2'd0,
    ModeProp  = 2'd1,
    ModeRatio = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [GainW-1:0]  gain;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] link0_idle_time;
    logic [TimeW-1:0] link0_total_time;
    logic [TimeW-1:0] link1_idle_time;
    logic [TimeW-1:0] link1_total_time;
  } in_item_t;

  typedef struct packed {
    logic [QW-1:0] occupancy_link0;
    logic [QW-1:0] occupancy_link1;
    logic [QW-1:0] split_prob;
    logic          split_applied;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/mlsc_div.sv
// ----------------------------------------------------------------------------
// mlsc_div: shared radix-2 restoring divider
// Computes floor(num * 2^FracBits / den) for num <= den, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mlsc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mlsc_pkg::TimeW-1:0]  num_i,
  input  logic [mlsc_pkg::TimeW-1:0]  den_i,
  output logic                        done_o,
  output logic [mlsc_pkg::QW-1:0]     quot_o
);

  localparam int unsigned TW   = mlsc_pkg::TimeW;
  localparam int unsigned QW   = mlsc_pkg::QW;
  localparam int unsigned CntW = $clog2(QW);

  logic [TW:0]     rem_q, rem_d;
  logic [TW-1:0]   den_q;
  logic [QW-1:0]   quot_q, quot_d;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic            ge;
  logic [TW:0]     diff, kept;

  // The partial remainder stays below twice the divisor, so one compare
  // and subtract settles each quotient bit.
  always_comb begin
    diff   = rem_q - {1'b0, den_q};
    ge     = (rem_q >= {1'b0, den_q});
    kept   = ge ? diff : rem_q;
    rem_d  = {kept[TW-1:0], 1'b0};
    quot_d = {quot_q[QW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

>>> hw/rtl/mlsc_ctrl.sv
// ----------------------------------------------------------------------------
// mlsc_ctrl: sequencer and datapath of the split controller
// Runs the occupancy divisions on the shared divider, then by mode either the
// ratio division or the proportional update, and hands the result to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mlsc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mlsc_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  mlsc_pkg::in_item_t    in_data_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output mlsc_pkg::out_item_t   res_o
);

  localparam int unsigned TW = mlsc_pkg::TimeW;
  localparam int unsigned QW = mlsc_pkg::QW;
  localparam int unsigned GW = mlsc_pkg::GainW;
  localparam int unsigned GF = mlsc_pkg::GainFrac;
  localparam int unsigned PW = GW + QW;
  localparam int unsigned SW = QW + 3;

  typedef enum logic [8:0] {
    SIdle = 9'b000000001,
    SL0   = 9'b000000010,
    SW0   = 9'b000000100,
    SL1   = 9'b000001000,
    SW1   = 9'b000010000,
    SMix  = 9'b000100000,
    SAdj  = 9'b001000000,
    SWr   = 9'b010000000,
    SOut  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  mlsc_pkg::in_item_t item_q;
  logic [QW-1:0] occ0_q, occ1_q, prob_q, split_q;
  logic          applied_q;
  logic [PW-1:0] prod_q;
  logic          neg_q;

  logic          div_start, div_done;
  logic [TW-1:0] div_num, div_den;
  logic [QW-1:0] div_quot;

  logic          skip0, skip1;
  logic [QW:0]   occ_sum;
  logic [QW-1:0] occ_mag;
  logic [PW:0]   prod_round;
  logic [QW:0]   delta_mag;
  logic signed [SW-1:0] adj_sum;
  logic [QW-1:0] adj_clamped, ratio_clamped;

  mlsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // A zero window or an idle time beyond the window gives zero occupancy.
  assign skip0 = (item_q.link0_total_time == '0) ||
                 (item_q.link0_idle_time > item_q.link0_total_time);
  assign skip1 = (item_q.link1_total_time == '0) ||
                 (item_q.link1_idle_time > item_q.link1_total_time);
  assign occ_sum = {1'b0, occ0_q} + {1'b0, occ1_q};
  assign occ_mag = (occ0_q >= occ1_q) ? (occ0_q - occ1_q) : (occ1_q - occ0_q);

  // A negative step rounds toward minus infinity, so its magnitude rounds up.
  always_comb begin
    prod_round = {1'b0, prod_q} + PW'({GF{1'b1}});
    if (neg_q) begin
      delta_mag = prod_round[PW:GF];
      adj_sum   = $signed({3'b000, split_q}) - $signed({2'b00, delta_mag});
    end else begin
      delta_mag = {1'b0, prod_q[PW-1:GF]};
      adj_sum   = $signed({3'b000, split_q}) + $signed({2'b00, delta_mag});
    end
    if (adj_sum < $signed({3'b000, mlsc_pkg::QLow})) begin
      adj_clamped = mlsc_pkg::QLow;
    end else if (adj_sum > $signed({3'b000, mlsc_pkg::QHigh})) begin
      adj_clamped = mlsc_pkg::QHigh;
    end else begin
      adj_clamped = adj_sum[QW-1:0];
    end
    if (div_quot < mlsc_pkg::QLow) begin
      ratio_clamped = mlsc_pkg::QLow;
    end else if (div_quot > mlsc_pkg::QHigh) begin
      ratio_clamped = mlsc_pkg::QHigh;
    end else begin
      ratio_clamped = div_quot;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          state_d = SL0;
        end
      end
      SL0: begin
        div_num = item_q.link0_total_time - item_q.link0_idle_time;
        div_den = item_q.link0_total_time;
        if (skip0) begin
          state_d = SL1;
        end else begin
          div_start = 1'b1;
          state_d   = SW0;
        end
      end
      SW0: begin
        if (div_done) begin
          state_d = SL1;
        end
      end
      SL1: begin
        div_num = item_q.link1_total_time - item_q.link1_idle_time;
        div_den = item_q.link1_total_time;
        if (skip1) begin
          state_d = SMix;
        end else begin
          div_start = 1'b1;
          state_d   = SW1;
        end
      end
      SW1: begin
        if (div_done) begin
          state_d = SMix;
        end
      end
      SMix: begin
        div_num = TW'(occ0_q);
        div_den = TW'(occ_sum);
        unique case (cfg_i.mode)
          mlsc_pkg::ModeProp: begin
            state_d = SAdj;
          end
          mlsc_pkg::ModeRatio: begin
            if (occ_sum == '0) begin
              state_d = SOut;
            end else begin
              div_start = 1'b1;
              state_d   = SWr;
            end
          end
          default: begin
            state_d = SOut;
          end
        endcase
      end
      SAdj: begin
        state_d = SOut;
      end
      SWr: begin
        if (div_done) begin
          state_d = SOut;
        end
      end
      SOut: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      split_q <= mlsc_pkg::QInit;
    end else begin
      state_q <= state_d;
      if (state_q == SAdj) begin
        split_q <= adj_clamped;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_valid_i) begin
      item_q <= in_data_i;
    end
    if (state_q == SL0) begin
      occ0_q <= '0;
    end else if (state_q == SW0 && div_done) begin
      occ0_q <= div_quot;
    end
    if (state_q == SL1) begin
      occ1_q <= '0;
    end else if (state_q == SW1 && div_done) begin
      occ1_q <= div_quot;
    end
    if (state_q == SMix) begin
      prod_q <= PW'(cfg_i.gain) * PW'(occ_mag);
      neg_q  <= (occ0_q < occ1_q);
      unique case (cfg_i.mode)
        mlsc_pkg::ModeProp: begin
          applied_q <= 1'b1;
        end
        mlsc_pkg::ModeRatio: begin
          prob_q    <= mlsc_pkg::QHalf;
          applied_q <= 1'b1;
        end
        default: begin
          prob_q    <= mlsc_pkg::QOne;
          applied_q <= 1'b0;
        end
      endcase
    end
    if (state_q == SAdj) begin
      prob_q <= adj_clamped;
    end
    if (state_q == SWr && div_done) begin
      prob_q <= ratio_clamped;
    end
  end

  assign in_ready_o  = (state_q == SIdle);
  assign res_valid_o = (state_q == SOut);
  assign res_o       = '{occupancy_link0: occ0_q,
                         occupancy_link1: occ1_q,
                         split_prob:      prob_q,
                         split_applied:   applied_q};

endmodule

`default_nettype wire

>>> hw/rtl/multi_link_split_controller.sv
// ----------------------------------------------------------------------------
// multi_link_split_controller: two-link occupancy and traffic split controller
// Turns one measurement window into link occupancies and a link1 split.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries one measurement window, the idle and
// total time of link0 and link1. Each yields exactly one output transaction
// with both busy fractions (unsigned Q16, 1.0 = 65536), the probability of
// steering traffic to link1 and a flag that tells whether the split is
// pushed to the traffic source. Both channels use valid/ready.
// The configuration channel writes sched_mode (index 0) and loop_gain
// (index 1); it is always ready and must only be used while the block idles.
// All divisions run one after the other on one shared bit-serial divider
// that retires one quotient bit per cycle; the ratio mode adds a third
// division for a nonzero occupancy sum, and a link with zero total or idle
// beyond total skips its division. The sequencer holds one window at a
// time, and the next window can be accepted in the cycle after the result
// moved into the output register; while that register is full, a second
// result waits in the sequencer until it frees, and the input stalls
// meanwhile. Reset restores mode 0, a gain of 0.2 and the adaptive split
// of 0.808, and leaves the output channel empty.
`default_nettype none

module multi_link_split_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  mlsc_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mlsc_pkg::out_item_t   out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i
);

  mlsc_pkg::cfg_t      cfg_q;
  mlsc_pkg::out_item_t res;
  mlsc_pkg::out_item_t out_q;
  logic                res_valid, res_ready;
  logic                out_valid_q;

  // Register writes are taken at any time; the user must keep them to idle time, as the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= mlsc_pkg::ModeFixed;
      cfg_q.gain <= mlsc_pkg::GainReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mlsc_pkg::CfgSchedMode: cfg_q.mode <= mlsc_pkg::mode_e'(cfg_data_i[1:0]);
        mlsc_pkg::CfgLoopGain:  cfg_q.gain <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mlsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // The output register frees the sequencer as soon as a result is handed
  // over; it refills in the same cycle in which the receiver takes its item.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for multi_link_split_controller
// Drives measurement windows through the valid/ready input channel, predicts
// each result from a local copy of the split state and configuration, and
// compares every output transaction field by field in arrival order.
// ----------------------------------------------------------------------------

module testbench;

  // Selector value with no defined meaning; the block treats it as fixed mode.
  localparam logic [1:0] ModeSpare = 2'd3;
  // Register index that addresses nothing; a write there must change nothing.
  localparam logic [1:0] CfgUnused = 2'd2;

  localparam logic [mlsc_pkg::TimeW-1:0] MaxTime = '1;
  localparam int unsigned RandomPhases   = 10;
  localparam int unsigned PhaseWindows   = 123;
  localparam int unsigned LongHoldCycles = 400;
  // Twice the worst item latency of the block, waited out at the end.
  localparam int unsigned DrainCycles    = 2 * (3 * mlsc_pkg::FracBits + 10);
  localparam int unsigned CycleLimit     = 1_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Block inputs start at known values before the first clock edge.
  logic                logic_unused_guard;
  logic                in_valid = 1'b0;
  mlsc_pkg::in_item_t  in_data = '0;
  logic                out_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [15:0]         cfg_data = '0;

  logic                in_ready;
  logic                out_valid;
  mlsc_pkg::out_item_t out_data;
  logic                cfg_ready;

  // Mirror of the block's registers and of its adaptive split.
  logic [1:0]                 cfg_mode = mlsc_pkg::ModeFixed;
  logic [mlsc_pkg::GainW-1:0] cfg_gain = mlsc_pkg::GainReset;
  logic [mlsc_pkg::QW-1:0]    split_state = mlsc_pkg::QInit;

  mlsc_pkg::in_item_t  pending_windows[$];
  mlsc_pkg::out_item_t expected_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  int unsigned error_count = 0;
  int unsigned results_checked = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned clamp_low_hits = 0;
  int unsigned clamp_high_hits = 0;
  int unsigned windows_by_mode[4] = '{0, 0, 0, 0};
  int unsigned cycle_count = 0;

  assign logic_unused_guard = 1'b0;

  multi_link_split_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Busy fraction of one link in unsigned Q format, floored. A window with
  // no traced time, or with more idle than total time, counts as fully idle.
  function automatic logic [mlsc_pkg::QW-1:0] busy_q(logic [mlsc_pkg::TimeW-1:0] idle,
                                                     logic [mlsc_pkg::TimeW-1:0] total);
    logic [63:0] busy;
    if (total == '0 || idle > total) return '0;
    busy = 64'(total - idle) << mlsc_pkg::FracBits;
    return mlsc_pkg::QW'(busy / 64'(total));
  endfunction

  // Limits a split to the band [0.05, 0.95] and keeps count of the hits.
  function automatic logic [mlsc_pkg::QW-1:0] clamp_split(longint signed value);
    if (value < longint'(mlsc_pkg::QLow)) begin
      clamp_low_hits++;
      return mlsc_pkg::QLow;
    end
    if (value > longint'(mlsc_pkg::QHigh)) begin
      clamp_high_hits++;
      return mlsc_pkg::QHigh;
    end
    return mlsc_pkg::QW'(value);
  endfunction

  // Works out the result of one window under the current configuration and
  // advances the adaptive split when the proportional controller is active.
  function automatic mlsc_pkg::out_item_t predict_split(mlsc_pkg::in_item_t w);
    mlsc_pkg::out_item_t     r;
    logic [mlsc_pkg::QW-1:0] occ0;
    logic [mlsc_pkg::QW-1:0] occ1;
    longint unsigned         mag;
    longint unsigned         sum;
    longint signed           delta;
    occ0 = busy_q(w.link0_idle_time, w.link0_total_time);
    occ1 = busy_q(w.link1_idle_time, w.link1_total_time);
    r.occupancy_link0 = occ0;
    r.occupancy_link1 = occ1;
    r.split_prob = mlsc_pkg::QOne;
    r.split_applied = 1'b0;
    if (cfg_mode == mlsc_pkg::ModeProp) begin
      // The gain product is floored toward minus infinity, so a negative
      // step rounds its magnitude up.
      if (occ0 >= occ1) begin
        mag = longint'(cfg_gain) * longint'(occ0 - occ1);
        delta = longint'(mag >> mlsc_pkg::GainFrac);
      end else begin
        mag = longint'(cfg_gain) * longint'(occ1 - occ0);
        delta = -longint'((mag + ((64'd1 << mlsc_pkg::GainFrac) - 1))
                          >> mlsc_pkg::GainFrac);
      end
      split_state = clamp_split(longint'(split_state) + delta);
      r.split_prob = split_state;
      r.split_applied = 1'b1;
    end else if (cfg_mode == mlsc_pkg::ModeRatio) begin
      sum = longint'(occ0) + longint'(occ1);
      if (sum == 0) r.split_prob = mlsc_pkg::QHalf;
      else r.split_prob = clamp_split(
          longint'((longint'(occ0) << mlsc_pkg::FracBits) / sum));
      r.split_applied = 1'b1;
    end
    return r;
  endfunction

  // Input driver. A new transaction is offered only when the channel is free
  // after this edge: either nothing was offered or the offer was taken. The
  // prediction is made at the edge that accepts the window.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_ready) input_stall_cycles++;
      if (!in_valid || in_ready) begin
        if (in_valid) begin
          windows_by_mode[cfg_mode]++;
          expected_results.insert(expected_results.size(), predict_split(in_data));
        end
        if (pending_windows.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= pending_windows.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side ready. A toggle of hold_req starts one long hold-off that is
  // counted here; otherwise ready is dropped at random.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LongHoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Output monitor: every accepted result transaction is matched against the
  // oldest outstanding prediction.
  always @(posedge clk) begin : result_check
    mlsc_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: %p", out_data);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_data.occupancy_link0 !== want.occupancy_link0) begin
          $error("occupancy_link0: expected %0d, actual %0d",
                 want.occupancy_link0, out_data.occupancy_link0);
          error_count++;
        end
        if (out_data.occupancy_link1 !== want.occupancy_link1) begin
          $error("occupancy_link1: expected %0d, actual %0d",
                 want.occupancy_link1, out_data.occupancy_link1);
          error_count++;
        end
        if (out_data.split_prob !== want.split_prob) begin
          $error("split_prob: expected %0d, actual %0d",
                 want.split_prob, out_data.split_prob);
          error_count++;
        end
        if (out_data.split_applied !== want.split_applied) begin
          $error("split_applied: expected %0d, actual %0d",
                 want.split_applied, out_data.split_applied);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("multi_link_split_controller verification failed");
      $finish;
    end
  end

  // Writes one register through the configuration channel and updates the
  // mirror once the transaction is taken. Only called while the block idles.
  task automatic write_register(input logic [1:0] index, input logic [15:0] value);
    @(posedge clk);
    cfg_index <= index;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == mlsc_pkg::CfgSchedMode) cfg_mode = value[1:0];
    else if (index == mlsc_pkg::CfgLoopGain) cfg_gain = value;
  endtask

  task automatic push_window(input logic [mlsc_pkg::TimeW-1:0] idle0,
                             input logic [mlsc_pkg::TimeW-1:0] total0,
                             input logic [mlsc_pkg::TimeW-1:0] idle1,
                             input logic [mlsc_pkg::TimeW-1:0] total1);
    mlsc_pkg::in_item_t w;
    w.link0_idle_time = idle0;
    w.link0_total_time = total0;
    w.link1_idle_time = idle1;
    w.link1_total_time = total1;
    pending_windows.insert(pending_windows.size(), w);
  endtask

  // Returns once every queued window has been taken and every predicted
  // result has arrived; the block is idle from then on.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_windows.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  initial begin : stimulus
    logic [1:0]                 next_mode;
    logic [mlsc_pkg::GainW-1:0] next_gain;
    logic [mlsc_pkg::TimeW-1:0] idle_t[2];
    logic [mlsc_pkg::TimeW-1:0] total_t[2];
    int unsigned                kind;
    int unsigned                span;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset configuration: fixed mode. Zero totals, idle beyond total, full
    // and empty links at the extremes of the time fields, and a floored third.
    push_window('0, '0, '0, '0);
    push_window(MaxTime, 30'd5, 30'd7, 30'd3);
    push_window('0, MaxTime, MaxTime, MaxTime);
    push_window(MaxTime, MaxTime, '0, 30'd1);
    push_window(30'd1, 30'd3, 30'd2, 30'd3);
    wait_drained();

    // Proportional mode on the reset gain and reset split: a step up into
    // the upper clamp, steps down with rounding of negative products, a run
    // down into the lower clamp, and a zero step.
    write_register(mlsc_pkg::CfgSchedMode, 16'(mlsc_pkg::ModeProp));
    @(negedge clk);
    push_window('0, 30'd1, 30'd1, 30'd1);
    push_window(30'd1, 30'd1, '0, 30'd1);
    push_window(30'd1, 30'd3, 30'd2, 30'd3);
    push_window(30'd2, 30'd3, 30'd1, 30'd3);
    repeat (4) push_window(30'd1, 30'd1, '0, 30'd1);
    push_window('0, '0, '0, '0);
    wait_drained();

    // Ratio mode: zero occupancy sum gives one half, then both clamps.
    write_register(mlsc_pkg::CfgSchedMode, 16'(mlsc_pkg::ModeRatio));
    @(negedge clk);
    push_window('0, '0, '0, '0);
    push_window('0, 30'd1, 30'd1, 30'd1);
    push_window(30'd1, 30'd1, '0, 30'd1);
    push_window(30'd1, 30'd3, 30'd2, 30'd3);
    push_window(30'd5, 30'd4, '0, MaxTime);
    wait_drained();

    // The spare selector value, written with its unused data bits set, must
    // act as fixed mode; a write to an unused index must leave it alone.
    write_register(mlsc_pkg::CfgSchedMode, {14'h3FFF, ModeSpare});
    @(negedge clk);
    push_window('0, 30'd1, 30'd1, 30'd1);
    wait_drained();
    write_register(CfgUnused, 16'h0001);
    @(negedge clk);
    push_window(30'd1, 30'd1, '0, 30'd1);
    wait_drained();

    // Random phases. Each one sets both registers, picks an idling pattern
    // and sends a batch of windows. Most links get a well-formed window with
    // idle no longer than total; the rest are zero totals, idle beyond
    // total, raw 30-bit noise, and fully idle or fully busy links.
    for (int unsigned ph = 0; ph < RandomPhases; ph++) begin
      next_gain = mlsc_pkg::GainW'($urandom());
      case (ph % 5)
        0: begin
          next_mode = mlsc_pkg::ModeProp;
          next_gain = '1;
        end
        1: next_mode = mlsc_pkg::ModeRatio;
        2: begin
          next_mode = mlsc_pkg::ModeProp;
          next_gain = '0;
        end
        3: next_mode = mlsc_pkg::ModeFixed;
        default: next_mode = mlsc_pkg::ModeProp;
      endcase
      if (ph == 7) next_mode = ModeSpare;
      write_register(mlsc_pkg::CfgLoopGain, next_gain);
      write_register(mlsc_pkg::CfgSchedMode, {14'($urandom()), next_mode});
      @(negedge clk);

      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 84;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 84;
        end
        default: begin
          send_idle_pct = 31;
          recv_stall_pct = 31;
        end
      endcase

      for (int unsigned n = 0; n < PhaseWindows; n++) begin
        for (int unsigned link = 0; link < 2; link++) begin
          kind = $urandom_range(0, 99);
          span = $urandom_range(1, mlsc_pkg::TimeW);
          total_t[link] = mlsc_pkg::TimeW'($urandom() >> (32 - span));
          if (kind < 60) begin
            idle_t[link] = mlsc_pkg::TimeW'($urandom_range(0, total_t[link]));
          end else if (kind < 70) begin
            total_t[link] = '0;
            idle_t[link] = ($urandom_range(0, 1) != 0) ? mlsc_pkg::TimeW'($urandom()) : '0;
          end else if (kind < 80) begin
            if (total_t[link] == MaxTime) total_t[link] = MaxTime - 1;
            idle_t[link] = mlsc_pkg::TimeW'($urandom_range(total_t[link] + 1, MaxTime));
          end else if (kind < 90) begin
            total_t[link] = mlsc_pkg::TimeW'($urandom());
            idle_t[link] = mlsc_pkg::TimeW'($urandom());
          end else begin
            idle_t[link] = ($urandom_range(0, 1) != 0) ? total_t[link] : '0;
          end
        end
        push_window(idle_t[0], total_t[0], idle_t[1], total_t[1]);
      end

      // In one full-rate phase the receiver holds off for a long stretch
      // while windows keep coming, so the block fills and stalls its input.
      if (ph == 4) hold_req = ~hold_req;
      wait_drained();
    end

    // Let any stray result surface before the verdict.
    repeat (DrainCycles) @(negedge clk);

    $display("Checked %0d results: %0d fixed, %0d proportional, %0d ratio, %0d spare mode.",
             results_checked, windows_by_mode[mlsc_pkg::ModeFixed],
             windows_by_mode[mlsc_pkg::ModeProp],
             windows_by_mode[mlsc_pkg::ModeRatio], windows_by_mode[ModeSpare]);
    $display("Split clamped low %0d and high %0d times; input stalled for %0d cycles.",
             clamp_low_hits, clamp_high_hits, input_stall_cycles);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("multi_link_split_controller verification clean");
    end else begin
      $display("multi_link_split_controller verification failed");
    end
    $finish;
  end

endmodule

>>> multi_link_split_controller.f
hw/rtl/mlsc_pkg.sv
hw/rtl/mlsc_div.sv
hw/rtl/mlsc_ctrl.sv
hw/rtl/multi_link_split_controller.sv
tb/testbench.sv
